### rtl/pppdm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pppdm_pkg;

    localparam int TIME_W  = 32;
    localparam int CLK_W   = 29;
    localparam int FREQ_W  = 37;
    localparam int DUTY_W  = 15;
    localparam int PROD_W  = TIME_W + DUTY_W;
    localparam int FREQ_SHIFT = FREQ_W - CLK_W;
    localparam int CNT_W   = 6;

    localparam logic [CLK_W-1:0]  CLK_HZ_RESET = CLK_W'(200000000);
    localparam logic [DUTY_W-1:0] DUTY_FULL    = DUTY_W'(25600);

    typedef struct packed {
        logic [TIME_W-1:0] count;
        logic [TIME_W-1:0] period;
        logic [TIME_W-1:0] high;
    } t_job;

    typedef struct packed {
        logic push;
        logic pop;
    } t_q_ctl;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

### rtl/pppdm_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module pppdm_fifo (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  pppdm_pkg::t_q_ctl   i_ctl,
    input  pppdm_pkg::t_job     i_job,
    output pppdm_pkg::t_q_stat  o_stat,
    output pppdm_pkg::t_job     o_job
);

    pppdm_pkg::t_job r_mem [2];
    logic            r_wr_ptr;
    logic            r_rd_ptr;
    logic [1:0]      r_fill;
    logic            n_wr_ptr;
    logic            n_rd_ptr;
    logic [1:0]      n_fill;
    logic            w_push;
    logic            w_pop;

    assign o_stat = '{full: (r_fill == 2'd2), empty: (r_fill == 2'd0)};
    assign w_push = i_ctl.push && !o_stat.full;
    assign w_pop  = i_ctl.pop && !o_stat.empty;
    assign o_job  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = w_push ? !r_wr_ptr : r_wr_ptr;
        n_rd_ptr = w_pop ? !r_rd_ptr : r_rd_ptr;
        n_fill   = r_fill + 2'(w_push) - 2'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

`default_nettype wire

### rtl/pppdm_front.sv
`timescale 1ns / 1ps
`default_nettype none

module pppdm_front (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_in_valid,
    output logic                           o_in_stall,
    input  wire  [pppdm_pkg::TIME_W-1:0]   i_edge_time,
    input  wire                            i_level_high,
    input  pppdm_pkg::t_q_stat             i_q_stat,
    output logic                           o_push,
    output pppdm_pkg::t_job                o_job
);

    logic [pppdm_pkg::TIME_W-1:0] r_prev_rise;
    logic [pppdm_pkg::TIME_W-1:0] r_last_fall;
    logic [pppdm_pkg::TIME_W-1:0] r_rise_cnt;
    logic [pppdm_pkg::TIME_W-1:0] n_rise_cnt;
    logic                         w_accept;

    assign o_in_stall = i_q_stat.full;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign o_push     = w_accept && i_level_high;
    assign n_rise_cnt = r_rise_cnt + pppdm_pkg::TIME_W'(1);

    always_comb begin
        o_job.count  = n_rise_cnt;
        o_job.period = i_edge_time - r_prev_rise;
        o_job.high   = r_last_fall - r_prev_rise;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_rise <= '0;
            r_last_fall <= '0;
            r_rise_cnt  <= '0;
        end else if (w_accept) begin
            if (i_level_high) begin
                r_prev_rise <= i_edge_time;
                r_rise_cnt  <= n_rise_cnt;
            end else begin
                r_last_fall <= i_edge_time;
            end
        end
    end

endmodule

`default_nettype wire

### rtl/pppdm_back.sv
`timescale 1ns / 1ps
`default_nettype none

module pppdm_back (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire  [pppdm_pkg::CLK_W-1:0]    i_clk_hz,
    input  pppdm_pkg::t_q_stat             i_q_stat,
    input  pppdm_pkg::t_job                i_job,
    output logic                           o_pop,
    output logic                           o_out_valid,
    input  wire                            i_out_stall,
    output logic [pppdm_pkg::TIME_W-1:0]   o_pulse_count,
    output logic [pppdm_pkg::TIME_W-1:0]   o_period_ticks,
    output logic [pppdm_pkg::TIME_W-1:0]   o_high_ticks,
    output logic [pppdm_pkg::FREQ_W-1:0]   o_frequency_q8,
    output logic [pppdm_pkg::DUTY_W-1:0]   o_duty_q8
);

    localparam int TW = pppdm_pkg::TIME_W;
    localparam int FW = pppdm_pkg::FREQ_W;
    localparam int DW = pppdm_pkg::DUTY_W;
    localparam int CW = pppdm_pkg::CNT_W;
    localparam int PW = pppdm_pkg::PROD_W;

    pppdm_pkg::t_state r_state;
    pppdm_pkg::t_state n_state;
    pppdm_pkg::t_job   r_job;
    logic [CW-1:0]     r_cnt;
    logic [TW-1:0]     r_frem;
    logic [FW-1:0]     r_fsh;
    logic [TW-1:0]     r_drem;
    logic [DW-1:0]     r_dsh;
    logic              r_zero;
    logic              r_sat;
    logic              r_out_valid;
    logic              w_load_out;
    logic [PW-1:0]     w_prod;
    logic [TW:0]       w_fr_sh;
    logic [TW:0]       w_fr_sub;
    logic              w_fge;
    logic [TW:0]       w_dr_sh;
    logic [TW:0]       w_dr_sub;
    logic              w_dge;

    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state    = r_state;
        o_pop      = 1'b0;
        w_load_out = 1'b0;
        unique case (r_state)
            pppdm_pkg::ST_IDLE: begin
                if (!i_q_stat.empty) begin
                    o_pop   = 1'b1;
                    n_state = pppdm_pkg::ST_MUL;
                end
            end
            pppdm_pkg::ST_MUL: begin
                n_state = pppdm_pkg::ST_DIV;
            end
            pppdm_pkg::ST_DIV: begin
                if (r_cnt == CW'(FW - 1)) begin
                    n_state = pppdm_pkg::ST_DONE;
                end
            end
            pppdm_pkg::ST_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    w_load_out = 1'b1;
                    n_state    = pppdm_pkg::ST_IDLE;
                end
            end
            default: n_state = pppdm_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pppdm_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // restoring divide steps, one quotient bit per cycle each
    assign w_prod   = PW'(r_job.high) * PW'(pppdm_pkg::DUTY_FULL);
    assign w_fr_sh  = {r_frem, r_fsh[FW-1]};
    assign w_fr_sub = w_fr_sh - {1'b0, r_job.period};
    assign w_fge    = (w_fr_sh >= {1'b0, r_job.period});
    assign w_dr_sh  = {r_drem, r_dsh[DW-1]};
    assign w_dr_sub = w_dr_sh - {1'b0, r_job.period};
    assign w_dge    = (w_dr_sh >= {1'b0, r_job.period});

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
        end
        if (r_state == pppdm_pkg::ST_MUL) begin
            r_cnt  <= '0;
            r_frem <= '0;
            r_fsh  <= {i_clk_hz, pppdm_pkg::FREQ_SHIFT'(0)};
            r_drem <= w_prod[PW-1:DW];
            r_dsh  <= w_prod[DW-1:0];
            r_zero <= (r_job.period == '0);
            r_sat  <= (r_job.high >= r_job.period);
        end
        if (r_state == pppdm_pkg::ST_DIV) begin
            r_cnt  <= r_cnt + CW'(1);
            r_frem <= w_fge ? w_fr_sub[TW-1:0] : w_fr_sh[TW-1:0];
            r_fsh  <= {r_fsh[FW-2:0], w_fge};
            if (r_cnt < CW'(DW)) begin
                r_drem <= w_dge ? w_dr_sub[TW-1:0] : w_dr_sh[TW-1:0];
                r_dsh  <= {r_dsh[DW-2:0], w_dge};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            o_pulse_count  <= r_job.count;
            o_period_ticks <= r_job.period;
            o_high_ticks   <= r_job.high;
            o_frequency_q8 <= r_zero ? '0 : r_fsh;
            if (r_zero) begin
                o_duty_q8 <= '0;
            end else if (r_sat) begin
                o_duty_q8 <= pppdm_pkg::DUTY_FULL;
            end else begin
                o_duty_q8 <= r_dsh;
            end
        end
    end

endmodule

`default_nettype wire

### rtl/pulse_period_duty_meter.sv
// a rising edge's job is queued, popped, multiplied, divided, then output with valid
// rising-edge jobs run one at a time through the 37-step frequency divider
// falling edges are taken one per cycle while the two-entry job queue has room
// reset (synchronous, active low) clears timestamps, pulse count, queue and output valid
// clock rate register resets to 200000000
`timescale 1ns / 1ps
`default_nettype none

module pulse_period_duty_meter (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_in_valid,
    output logic                           o_in_stall,
    input  wire  [pppdm_pkg::TIME_W-1:0]   i_edge_time,
    input  wire                            i_level_high,
    output logic                           o_out_valid,
    input  wire                            i_out_stall,
    output logic [pppdm_pkg::TIME_W-1:0]   o_pulse_count,
    output logic [pppdm_pkg::TIME_W-1:0]   o_period_ticks,
    output logic [pppdm_pkg::TIME_W-1:0]   o_high_ticks,
    output logic [pppdm_pkg::FREQ_W-1:0]   o_frequency_q8,
    output logic [pppdm_pkg::DUTY_W-1:0]   o_duty_q8,
    input  wire                            i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire  [pppdm_pkg::CLK_W-1:0]    i_cfg_data
);

    logic [pppdm_pkg::CLK_W-1:0] r_clk_hz;
    logic                        w_push;
    logic                        w_pop;
    pppdm_pkg::t_q_ctl           w_q_ctl;
    pppdm_pkg::t_q_stat          w_q_stat;
    pppdm_pkg::t_job             w_job_in;
    pppdm_pkg::t_job             w_job_out;

    assign o_cfg_ready = 1'b1;
    assign w_q_ctl     = '{push: w_push, pop: w_pop};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clk_hz <= pppdm_pkg::CLK_HZ_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_clk_hz <= i_cfg_data;
        end
    end

    pppdm_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_edge_time  (i_edge_time),
        .i_level_high (i_level_high),
        .i_q_stat     (w_q_stat),
        .o_push       (w_push),
        .o_job        (w_job_in)
    );

    pppdm_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_q_ctl),
        .i_job   (w_job_in),
        .o_stat  (w_q_stat),
        .o_job   (w_job_out)
    );

    pppdm_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_clk_hz       (r_clk_hz),
        .i_q_stat       (w_q_stat),
        .i_job          (w_job_out),
        .o_pop          (w_pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_pulse_count  (o_pulse_count),
        .o_period_ticks (o_period_ticks),
        .o_high_ticks   (o_high_ticks),
        .o_frequency_q8 (o_frequency_q8),
        .o_duty_q8      (o_duty_q8)
    );

endmodule

`default_nettype wire

### tb/pulse_period_duty_meter_tb.sv
`timescale 1ns / 1ps

module pulse_period_duty_meter_tb;

    localparam int TIME_W = pppdm_pkg::TIME_W;
    localparam int CLK_W  = pppdm_pkg::CLK_W;
    localparam int FREQ_W = pppdm_pkg::FREQ_W;
    localparam int DUTY_W = pppdm_pkg::DUTY_W;
    localparam logic [CLK_W-1:0]  CLK_HZ_RESET = pppdm_pkg::CLK_HZ_RESET;
    localparam logic [DUTY_W-1:0] DUTY_FULL    = pppdm_pkg::DUTY_FULL;

    localparam logic LVL_FALL = 1'b0;
    localparam logic LVL_RISE = 1'b1;
    localparam int SETTLE_CYCLES  = 60;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 100;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASES         = 12;
    localparam int PHASE_ITEMS    = 104;

    typedef struct packed {
        logic [TIME_W-1:0] count;
        logic [TIME_W-1:0] period;
        logic [TIME_W-1:0] high;
        logic [FREQ_W-1:0] freq;
        logic [DUTY_W-1:0] duty;
    } t_meter_result;

    typedef enum logic {
        ROW_EDGE,
        ROW_CFG
    } t_row_kind;

    typedef struct packed {
        t_row_kind         kind;
        logic [CLK_W-1:0]  clk_hz;
        logic [TIME_W-1:0] t;
        logic              lvl;
        logic              typed;
        logic [TIME_W-1:0] w_count;
        logic [TIME_W-1:0] w_period;
        logic [TIME_W-1:0] w_high;
        logic [FREQ_W-1:0] w_freq;
        logic [DUTY_W-1:0] w_duty;
    } t_row;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic [TIME_W-1:0] in_time = '0;
    logic              in_level = 1'b0;
    logic              out_stall = 1'b0;
    logic              cfg_valid = 1'b0;
    logic [CLK_W-1:0]  cfg_data = '0;

    wire               o_in_stall;
    wire               o_out_valid;
    wire               o_cfg_ready;
    wire [TIME_W-1:0]  o_pulse_count;
    wire [TIME_W-1:0]  o_period_ticks;
    wire [TIME_W-1:0]  o_high_ticks;
    wire [FREQ_W-1:0]  o_frequency_q8;
    wire [DUTY_W-1:0]  o_duty_q8;

    // predictor state
    logic [CLK_W-1:0]  clk_hz_q = CLK_HZ_RESET;
    logic [TIME_W-1:0] last_rise_q = '0;
    logic [TIME_W-1:0] last_fall_q = '0;
    logic [TIME_W-1:0] rise_cnt_q = '0;

    t_meter_result pending_measurements[$];
    t_row          plan[$];

    int unsigned items_sent = 0;
    int unsigned errors = 0;
    int unsigned quiet_cycles = 0;
    bit          gaps_on = 1'b1;
    bit          stall_on = 1'b1;
    bit          hold_req = 1'b0;

    pulse_period_duty_meter dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (o_in_stall),
        .i_edge_time    (in_time),
        .i_level_high   (in_level),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (out_stall),
        .o_pulse_count  (o_pulse_count),
        .o_period_ticks (o_period_ticks),
        .o_high_ticks   (o_high_ticks),
        .o_frequency_q8 (o_frequency_q8),
        .o_duty_q8      (o_duty_q8),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic int unsigned pick_len(input bit on);
        int unsigned r;
        r = $urandom_range(0, 19);
        if (!on || r < 10) return 0;
        if (r < 17) return $urandom_range(1, 3);
        return $urandom_range(15, 50);
    endfunction

    task automatic predict_edge(input logic [TIME_W-1:0] t, input logic lvl,
                                output logic has, output t_meter_result r);
        logic [63:0] duty_w;
        r = '0;
        has = 1'b0;
        if (lvl == LVL_FALL) begin
            last_fall_q = t;
        end else begin
            has = 1'b1;
            rise_cnt_q = rise_cnt_q + 1'b1;
            r.count = rise_cnt_q;
            r.period = t - last_rise_q;
            r.high = last_fall_q - last_rise_q;
            if (r.period != '0) begin
                r.freq = FREQ_W'((64'(clk_hz_q) << 8) / 64'(r.period));
                duty_w = (64'(r.high) * 64'(DUTY_FULL)) / 64'(r.period);
                r.duty = (duty_w > 64'(DUTY_FULL)) ? DUTY_FULL : DUTY_W'(duty_w);
            end
            last_rise_q = t;
        end
    endtask

    // one edge transaction, then a random gap on the input side
    task automatic offer_edge(input logic [TIME_W-1:0] t, input logic lvl,
                              input logic typed, input t_meter_result want);
        logic          has;
        t_meter_result got;
        int unsigned   gap;
        in_valid <= 1'b1;
        in_time <= t;
        in_level <= lvl;
        do @(posedge i_clk); while (o_in_stall);
        predict_edge(t, lvl, has, got);
        if (has) pending_measurements.push_back(typed ? want : got);
        items_sent++;
        gap = pick_len(gaps_on);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (pending_measurements.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_clock(input logic [CLK_W-1:0] hz);
        cfg_valid <= 1'b1;
        cfg_data <= hz;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        clk_hz_q = hz;
    endtask

    // receiver side
    initial begin
        int unsigned n;
        forever begin
            if (hold_req) begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
                out_stall <= 1'b0;
                @(posedge i_clk);
            end else begin
                n = pick_len(stall_on);
                if (n > 0) begin
                    out_stall <= 1'b1;
                    repeat (n) @(posedge i_clk);
                end
                out_stall <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        t_meter_result want;
        t_meter_result got;
        if (i_rst_n && o_out_valid && !out_stall) begin
            got = '{o_pulse_count, o_period_ticks, o_high_ticks,
                    o_frequency_q8, o_duty_q8};
            if (pending_measurements.size() == 0) begin
                errors++;
                $display("%0t: unexpected result cnt=%0d per=%0d hi=%0d freq=%0d duty=%0d",
                         $time, got.count, got.period, got.high, got.freq, got.duty);
            end else begin
                want = pending_measurements.pop_front();
                if (got !== want) begin
                    errors++;
                    $display("%0t: expected cnt=%0d per=%0d hi=%0d freq=%0d duty=%0d",
                             $time, want.count, want.period, want.high, want.freq,
                             want.duty);
                    $display("%0t: actual   cnt=%0d per=%0d hi=%0d freq=%0d duty=%0d",
                             $time, got.count, got.period, got.high, got.freq,
                             got.duty);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall)
                || (cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles at %0t", quiet_cycles, $time);
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int unsigned       phase;
        int unsigned       budget;
        logic [TIME_W-1:0] per;
        logic [TIME_W-1:0] hi;
        logic [TIME_W-1:0] t;
        logic [TIME_W-1:0] gen_t;
        logic              lvl;
        logic [CLK_W-1:0]  hz;
        t_meter_result     want;

        plan = '{
            '{ROW_EDGE, 29'd0, 32'd0, LVL_RISE, 1'b1, 32'd1, 32'd0, 32'd0, 37'd0, 15'd0},
            '{ROW_EDGE, 29'd0, 32'd250, LVL_FALL, 1'b0, 32'd0, 32'd0, 32'd0, 37'd0, 15'd0},
            '{ROW_EDGE, 29'd0, 32'd1000, LVL_RISE, 1'b1,
              32'd2, 32'd1000, 32'd250, 37'd51200000, 15'd6400},
            // zero period
            '{ROW_EDGE, 29'd0, 32'd1000, LVL_RISE, 1'b1,
              32'd3, 32'd0, 32'd4294966546, 37'd0, 15'd0},
            // high time above period
            '{ROW_EDGE, 29'd0, 32'd5000, LVL_FALL, 1'b0, 32'd0, 32'd0, 32'd0, 37'd0, 15'd0},
            '{ROW_EDGE, 29'd0, 32'd2000, LVL_RISE, 1'b1,
              32'd4, 32'd1000, 32'd4000, 37'd51200000, 15'd25600},
            // counter wrap
            '{ROW_EDGE, 29'd0, 32'hFFFFFF00, LVL_RISE, 1'b0, 32'd0, 32'd0, 32'd0, 37'd0, 15'd0},
            '{ROW_EDGE, 29'd0, 32'h00000010, LVL_FALL, 1'b0, 32'd0, 32'd0, 32'd0, 37'd0, 15'd0},
            '{ROW_EDGE, 29'd0, 32'h00000100, LVL_RISE, 1'b0, 32'd0, 32'd0, 32'd0, 37'd0, 15'd0},
            '{ROW_CFG, 29'h1FFFFFFF, 32'd0, LVL_FALL, 1'b0, 32'd0, 32'd0, 32'd0, 37'd0, 15'd0},
            '{ROW_EDGE, 29'd0, 32'h00000101, LVL_RISE, 1'b1,
              32'd7, 32'd1, 32'd4294967056, 37'd137438953216, 15'd25600},
            // longest period
            '{ROW_EDGE, 29'd0, 32'h00000100, LVL_RISE, 1'b0, 32'd0, 32'd0, 32'd0, 37'd0, 15'd0},
            '{ROW_CFG, 29'd0, 32'd0, LVL_FALL, 1'b0, 32'd0, 32'd0, 32'd0, 37'd0, 15'd0},
            '{ROW_EDGE, 29'd0, 32'h00000200, LVL_RISE, 1'b1,
              32'd9, 32'd256, 32'd4294967056, 37'd0, 15'd25600},
            '{ROW_CFG, 29'd1, 32'd0, LVL_FALL, 1'b0, 32'd0, 32'd0, 32'd0, 37'd0, 15'd0},
            '{ROW_EDGE, 29'd0, 32'hFFFFFFFF, LVL_FALL, 1'b0, 32'd0, 32'd0, 32'd0, 37'd0, 15'd0},
            '{ROW_EDGE, 29'd0, 32'h00000300, LVL_RISE, 1'b0, 32'd0, 32'd0, 32'd0, 37'd0, 15'd0},
            '{ROW_CFG, 29'd400000000, 32'd0, LVL_FALL, 1'b0,
              32'd0, 32'd0, 32'd0, 37'd0, 15'd0},
            '{ROW_EDGE, 29'd0, 32'h00000380, LVL_FALL, 1'b0, 32'd0, 32'd0, 32'd0, 37'd0, 15'd0},
            '{ROW_EDGE, 29'd0, 32'h00000400, LVL_RISE, 1'b0, 32'd0, 32'd0, 32'd0, 37'd0, 15'd0},
            '{ROW_CFG, CLK_HZ_RESET, 32'd0, LVL_FALL, 1'b0, 32'd0, 32'd0, 32'd0, 37'd0, 15'd0}
        };

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_CFG) begin
                settle();
                write_clock(plan[i].clk_hz);
            end else begin
                want = '{plan[i].w_count, plan[i].w_period, plan[i].w_high,
                         plan[i].w_freq, plan[i].w_duty};
                offer_edge(plan[i].t, plan[i].lvl, plan[i].typed, want);
            end
        end

        gen_t = 32'h00000400;
        for (phase = 0; phase < PHASES; phase++) begin
            settle();
            case (phase % 6)
                0: hz = CLK_HZ_RESET;
                1: hz = 29'h1FFFFFFF;
                2: hz = 29'd0;
                3: hz = 29'd1;
                4: hz = 29'd400000000;
                default: hz = CLK_W'($urandom_range(1, 400000000));
            endcase
            write_clock(hz);
            gaps_on = (phase % 4) != 3;
            stall_on = (phase % 5) != 4;
            // long receiver hold-off with back-to-back edges to fill the block
            if (phase == 6) begin
                gaps_on = 1'b0;
                hold_req = 1'b1;
            end
            budget = items_sent + PHASE_ITEMS;
            while (items_sent < budget) begin
                if ($urandom_range(0, 9) < 8) begin
                    case ($urandom_range(0, 4))
                        0: per = $urandom_range(0, 16);
                        1: per = $urandom_range(17, 100000);
                        2: per = $urandom;
                        3: per = $urandom_range(0, 1) ? 32'hFFFFFFFF : 32'd1;
                        default: per = $urandom_range(100, 5000);
                    endcase
                    if ($urandom_range(0, 9) == 0) hi = $urandom;
                    else hi = $urandom_range(0, per);
                    offer_edge(gen_t + hi, LVL_FALL, 1'b0, '0);
                    gen_t = gen_t + per;
                    offer_edge(gen_t, LVL_RISE, 1'b0, '0);
                end else begin
                    t = $urandom;
                    lvl = 1'($urandom_range(0, 1));
                    offer_edge(t, lvl, 1'b0, '0);
                    if (lvl == LVL_RISE) gen_t = t;
                end
            end
        end

        in_valid <= 1'b0;
        while (pending_measurements.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
